FILE: design/bmst_pkg.sv
// ----------------------------------------------------------------------------
// bmst_pkg
// Shared types and constants for the Boruvka spanning tree unit.
// ----------------------------------------------------------------------------
package bmst_pkg;

	localparam int MAX_NODES   = 64;
	localparam int MAX_EDGES   = 256;
	localparam int NODE_W      = 6;
	localparam int COMP_W      = 7;
	localparam int EIDX_W      = 8;
	localparam int ECNT_W      = 9;
	localparam int WEIGHT_W    = 32;

	localparam logic [COMP_W-1:0] NODE_COUNT_RESET = COMP_W'(MAX_NODES);

	typedef struct packed {
		logic [NODE_W-1:0]          edge_u;
		logic [NODE_W-1:0]          edge_v;
		logic signed [WEIGHT_W-1:0] edge_weight;
		logic                       last_edge;
	} item_t;

	typedef struct packed {
		logic                       has_edge;
		logic [EIDX_W-1:0]          edge_index;
		logic [NODE_W-1:0]          tree_u;
		logic [NODE_W-1:0]          tree_v;
		logic signed [WEIGHT_W-1:0] tree_weight;
		logic [COMP_W-1:0]          component_count;
		logic                       error;
		logic                       last;
	} result_t;

endpackage

FILE: design/bmst_out_reg.sv
// ----------------------------------------------------------------------------
// bmst_out_reg
// One-entry result register with valid/stall toward the consumer.
// ----------------------------------------------------------------------------
module bmst_out_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bmst_pkg::result_t push_data,
	output logic            free,
	output logic            result_valid,
	input  logic            result_stall,
	output bmst_pkg::result_t result
);
	import bmst_pkg::*;

	logic    vld_q;
	result_t data_q;

	assign free         = !vld_q || !result_stall;
	assign result_valid = vld_q;
	assign result       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			data_q <= '0;
		end else if (free) begin
			vld_q <= push;
			if (push) begin
				data_q <= push_data;
			end
		end
	end

endmodule

FILE: design/boruvka_minimum_spanning_tree_unit.sv
// ----------------------------------------------------------------------------
// boruvka_minimum_spanning_tree_unit
// Edge loader plus Boruvka solver over a memory-held union-find.
// ----------------------------------------------------------------------------
// Loading: one edge beat per cycle; each in-range edge that fits is written into the edge memory.
// Solve after the last edge: parent/size init sweep over all 64 nodes, then per phase a scan of all
//   stored edges (two finds each plus, where the roots differ, two cheapest-entry updates; a find
//   reads one parent per hop) and a merge pass over node_count roots. Input stalls while solving.
// Results leave through a one-entry register; each tree edge is held back one slot so the final
//   one's last flag can be set. Reset: node_count 64, batch cleared, output empty.
module boruvka_minimum_spanning_tree_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  bmst_pkg::item_t          item,
	output logic                     result_valid,
	input  logic                     result_stall,
	output bmst_pkg::result_t        result,
	input  logic                     node_count_valid,
	output logic                     node_count_ready,
	input  logic [bmst_pkg::COMP_W-1:0] node_count
);
	import bmst_pkg::*;

	typedef enum logic [4:0] {
		S_LOAD, S_ERR, S_INIT, S_PHASE, S_SCAN, S_SC_DATA, S_SC_A, S_SC_B,
		S_CA, S_CB, S_FD_RD, S_FD_P, S_FD_G, S_MG_CHK, S_MG_CD, S_MG_ED,
		S_MG_A, S_MG_B, S_MG_SB, S_MG_J, S_MG_OUT, S_FIN
	} state_t;

	localparam int EW = 2 * NODE_W + WEIGHT_W;   // edge memory word
	localparam int CW = EIDX_W + WEIGHT_W;       // cheapest memory word

	state_t state_q, ret_q;

	logic [COMP_W-1:0]   node_count_q, n;
	logic [ECNT_W-1:0]   loaded_q, e_q;
	logic                bad_q;
	logic [COMP_W-1:0]   i_q, c_q, comps_q, prev_q;
	logic [NODE_W-1:0]   x_q, a_q;
	logic [NODE_W-1:0]   u_q, v_q;
	logic signed [WEIGHT_W-1:0] w_q;
	logic [COMP_W-1:0]   sa_q;
	logic [MAX_NODES-1:0] cvld_q;
	result_t             pend_q, nres_q;
	logic                pend_vld_q;

	// memories
	logic [EW-1:0]     edge_mem [MAX_EDGES];
	logic [NODE_W-1:0] par_mem  [MAX_NODES];
	logic [COMP_W-1:0] size_mem [MAX_NODES];
	logic [CW-1:0]     chp_mem  [MAX_NODES];

	logic [EW-1:0]     edge_rd;
	logic [NODE_W-1:0] par_rd;
	logic [COMP_W-1:0] size_rd;
	logic [CW-1:0]     chp_rd;

	logic [EIDX_W-1:0] edge_ra;
	logic [NODE_W-1:0] par_ra, size_ra, chp_ra;
	logic              edge_we, par_we, size_we, chp_we;
	logic [EIDX_W-1:0] edge_wa;
	logic [EW-1:0]     edge_wd;
	logic [NODE_W-1:0] par_wa, par_wd, size_wa, chp_wa;
	logic [COMP_W-1:0] size_wd;
	logic [CW-1:0]     chp_wd;

	logic              push, out_free;
	result_t           push_data;

	// accept/load decode
	logic accept, bad_node, full;
	logic [EIDX_W-1:0]          chp_idx;
	logic signed [WEIGHT_W-1:0] chp_w;
	logic [NODE_W-1:0]          ed_u, ed_v;
	logic signed [WEIGHT_W-1:0] ed_w;
	logic                       take_a, take_b, a_small;
	logic [COMP_W-1:0]          size_sum;

	// clamp node_count into 1..MAX_NODES
	always_comb begin
		if (node_count_q == '0) begin
			n = COMP_W'(1);
		end else if (node_count_q > COMP_W'(MAX_NODES)) begin
			n = COMP_W'(MAX_NODES);
		end else begin
			n = node_count_q;
		end
	end

	assign node_count_ready = 1'b1;
	assign item_stall       = (state_q != S_LOAD);
	assign accept           = item_valid && !item_stall;
	assign bad_node = ({1'b0, item.edge_u} >= n) || ({1'b0, item.edge_v} >= n);
	assign full     = (loaded_q == ECNT_W'(MAX_EDGES));

	assign {chp_idx, chp_w}     = chp_rd;
	assign {ed_u, ed_v, ed_w}   = edge_rd;
	// strict compare keeps the earliest edge on a tie
	assign take_a   = !cvld_q[a_q] || (w_q < chp_w);
	assign take_b   = !cvld_q[x_q] || (w_q < chp_w);
	assign a_small  = sa_q < size_rd;
	assign size_sum = sa_q + size_rd;

	// memory port muxing
	always_comb begin
		edge_ra = e_q[EIDX_W-1:0];
		par_ra  = x_q;
		size_ra = a_q;
		chp_ra  = a_q;
		edge_we = 1'b0;
		edge_wa = loaded_q[EIDX_W-1:0];
		edge_wd = {item.edge_u, item.edge_v, item.edge_weight};
		par_we  = 1'b0;
		par_wa  = x_q;
		par_wd  = par_rd;
		size_we = 1'b0;
		size_wa = i_q[NODE_W-1:0];
		size_wd = COMP_W'(1);
		chp_we  = 1'b0;
		chp_wa  = a_q;
		chp_wd  = {e_q[EIDX_W-1:0], w_q};
		case (state_q)
			S_LOAD: begin
				edge_we = accept && !bad_node && !full;
			end
			S_INIT: begin
				par_we  = 1'b1;
				par_wa  = i_q[NODE_W-1:0];
				par_wd  = i_q[NODE_W-1:0];
				size_we = 1'b1;
			end
			S_FD_P: begin
				par_ra = par_rd;
			end
			S_FD_G: begin
				par_we = 1'b1;
				par_ra = par_rd;
			end
			S_SC_B: begin
				chp_ra = a_q;
			end
			S_CA: begin
				chp_ra = x_q;
				chp_we = take_a;
				chp_wa = a_q;
			end
			S_CB: begin
				chp_we = take_b;
				chp_wa = x_q;
			end
			S_MG_CHK: begin
				chp_ra = c_q[NODE_W-1:0];
			end
			S_MG_CD: begin
				edge_ra = chp_idx;
			end
			S_MG_B: begin
				size_ra = a_q;
			end
			S_MG_SB: begin
				size_ra = x_q;
			end
			S_MG_J: begin
				par_we  = 1'b1;
				size_we = 1'b1;
				size_wd = size_sum;
				if (a_small) begin
					par_wa  = a_q;
					par_wd  = x_q;
					size_wa = x_q;
				end else begin
					par_wa  = x_q;
					par_wd  = a_q;
					size_wa = a_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (edge_we) begin
			edge_mem[edge_wa] <= edge_wd;
		end
		edge_rd <= edge_mem[edge_ra];
	end

	always_ff @(posedge clk) begin
		if (par_we) begin
			par_mem[par_wa] <= par_wd;
		end
		par_rd <= par_mem[par_ra];
	end

	always_ff @(posedge clk) begin
		if (size_we) begin
			size_mem[size_wa] <= size_wd;
		end
		size_rd <= size_mem[size_ra];
	end

	always_ff @(posedge clk) begin
		if (chp_we) begin
			chp_mem[chp_wa] <= chp_wd;
		end
		chp_rd <= chp_mem[chp_ra];
	end

	// result push decode
	always_comb begin
		push      = 1'b0;
		push_data = pend_q;
		case (state_q)
			S_ERR: begin
				push            = 1'b1;
				push_data       = '0;
				push_data.error = 1'b1;
				push_data.last  = 1'b1;
			end
			S_MG_OUT: begin
				push = pend_vld_q;
			end
			S_FIN: begin
				push = 1'b1;
				if (pend_vld_q) begin
					push_data.last = 1'b1;
				end else begin
					push_data                 = '0;
					push_data.component_count = n;
					push_data.last            = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	bmst_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push && out_free),
		.push_data    (push_data),
		.free         (out_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			ret_q        <= S_LOAD;
			node_count_q <= NODE_COUNT_RESET;
			loaded_q     <= '0;
			bad_q        <= 1'b0;
			e_q          <= '0;
			i_q          <= '0;
			c_q          <= '0;
			comps_q      <= '0;
			prev_q       <= '0;
			x_q          <= '0;
			a_q          <= '0;
			u_q          <= '0;
			v_q          <= '0;
			w_q          <= '0;
			sa_q         <= '0;
			cvld_q       <= '0;
			pend_q       <= '0;
			nres_q       <= '0;
			pend_vld_q   <= 1'b0;
		end else begin
			if (node_count_valid) begin
				node_count_q <= node_count;
			end
			case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (bad_node || full) begin
							bad_q <= 1'b1;
						end else begin
							loaded_q <= loaded_q + 1'b1;
						end
						if (item.last_edge) begin
							i_q <= '0;
							state_q <= (bad_q || bad_node || full) ? S_ERR : S_INIT;
						end
					end
				end
				S_ERR: begin
					if (out_free) begin
						loaded_q <= '0;
						bad_q    <= 1'b0;
						state_q  <= S_LOAD;
					end
				end
				S_INIT: begin
					i_q <= i_q + 1'b1;
					if (i_q == COMP_W'(MAX_NODES - 1)) begin
						comps_q    <= n;
						pend_vld_q <= 1'b0;
						state_q    <= S_PHASE;
					end
				end
				S_PHASE: begin
					prev_q <= comps_q;
					cvld_q <= '0;
					e_q    <= '0;
					state_q <= (comps_q > COMP_W'(1)) ? S_SCAN : S_FIN;
				end
				// edge scan: lightest crossing edge per root
				S_SCAN: begin
					if (e_q == loaded_q) begin
						c_q     <= '0;
						state_q <= S_MG_CHK;
					end else begin
						state_q <= S_SC_DATA;
					end
				end
				S_SC_DATA: begin
					u_q     <= ed_u;
					v_q     <= ed_v;
					w_q     <= ed_w;
					x_q     <= ed_u;
					ret_q   <= S_SC_A;
					state_q <= S_FD_RD;
				end
				S_SC_A: begin
					a_q     <= x_q;
					x_q     <= v_q;
					ret_q   <= S_SC_B;
					state_q <= S_FD_RD;
				end
				S_SC_B: begin
					if (a_q == x_q) begin
						e_q     <= e_q + 1'b1;
						state_q <= S_SCAN;
					end else begin
						state_q <= S_CA;
					end
				end
				S_CA: begin
					if (take_a) begin
						cvld_q[a_q] <= 1'b1;
					end
					state_q <= S_CB;
				end
				S_CB: begin
					if (take_b) begin
						cvld_q[x_q] <= 1'b1;
					end
					e_q     <= e_q + 1'b1;
					state_q <= S_SCAN;
				end
				// find with path halving; root ends up in x_q
				S_FD_RD: begin
					state_q <= S_FD_P;
				end
				S_FD_P: begin
					state_q <= (par_rd == x_q) ? ret_q : S_FD_G;
				end
				S_FD_G: begin
					x_q     <= par_rd;
					state_q <= S_FD_P;
				end
				// merge pass over roots in ascending order
				S_MG_CHK: begin
					if (c_q == n) begin
						state_q <= (comps_q == prev_q || comps_q <= COMP_W'(1)) ?
							S_FIN : S_PHASE;
					end else if (!cvld_q[c_q[NODE_W-1:0]]) begin
						c_q <= c_q + 1'b1;
					end else begin
						state_q <= S_MG_CD;
					end
				end
				S_MG_CD: begin
					e_q     <= {1'b0, chp_idx};
					state_q <= S_MG_ED;
				end
				S_MG_ED: begin
					u_q     <= ed_u;
					v_q     <= ed_v;
					w_q     <= ed_w;
					x_q     <= ed_u;
					ret_q   <= S_MG_A;
					state_q <= S_FD_RD;
				end
				S_MG_A: begin
					a_q     <= x_q;
					x_q     <= v_q;
					ret_q   <= S_MG_B;
					state_q <= S_FD_RD;
				end
				S_MG_B: begin
					if (a_q == x_q) begin
						c_q     <= c_q + 1'b1;
						state_q <= S_MG_CHK;
					end else begin
						state_q <= S_MG_SB;
					end
				end
				S_MG_SB: begin
					sa_q    <= size_rd;
					state_q <= S_MG_J;
				end
				S_MG_J: begin
					comps_q                <= comps_q - 1'b1;
					nres_q.has_edge        <= 1'b1;
					nres_q.edge_index      <= e_q[EIDX_W-1:0];
					nres_q.tree_u          <= u_q;
					nres_q.tree_v          <= v_q;
					nres_q.tree_weight     <= w_q;
					nres_q.component_count <= comps_q - 1'b1;
					nres_q.error           <= 1'b0;
					nres_q.last            <= 1'b0;
					state_q                <= S_MG_OUT;
				end
				S_MG_OUT: begin
					// previous tree edge goes out once the new one is known
					if (!pend_vld_q || out_free) begin
						pend_q     <= nres_q;
						pend_vld_q <= 1'b1;
						c_q        <= c_q + 1'b1;
						state_q    <= S_MG_CHK;
					end
				end
				S_FIN: begin
					if (out_free) begin
						pend_vld_q <= 1'b0;
						loaded_q   <= '0;
						bad_q      <= 1'b0;
						state_q    <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule
